@@ rtl/ohl_pkg.sv @@
// ohl_pkg: shared constants, codes and control structs for the ordered handle list
// used by ohl_ctrl, ohl_dp and ordered_handle_list_core
`timescale 1ns / 1ps

package ohl_pkg;

  // default list depth
  localparam int CAPACITY_DEF = 64;

  // field widths
  localparam int OP_W     = 2;
  localparam int HANDLE_W = 16;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 48;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_GET    = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch request word, arm the walk
    logic walk;   // advance the remove walk one step
    logic fin;    // commit the operation and load the result register
  } ohl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] in_op;      // op of the word waiting at the input
    logic            walk_done;  // all entries read and handled
    logic            out_busy;   // result register still occupied
  } ohl_sts_t;

endpackage

@@ rtl/ordered_handle_list_core.sv @@
// ordered_handle_list_core: insertion-ordered list of up to CAPACITY 16-bit handles
// append goes to commit, get reads its position then commits, remove walks the list then commits;
// one word in flight, next word taken once the previous one has committed
// remove speed is set by the single read port walking the entry memory once per entry
// reset (rst, synchronous, active high) empties the list; entry memory is not cleared
`timescale 1ns / 1ps

module ordered_handle_list_core #(
  parameter int CAPACITY = ohl_pkg::CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // input word
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [ohl_pkg::IN_W-1:0]  s_tdata,   // op[1:0], handle[17:2], position[23:18]
  // result word
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [ohl_pkg::OUT_W-1:0] m_tdata    // status[1:0], fetched[17:2], length[24:18],
                                               // largest[40:25], largest_valid[41], zero above
);
  import ohl_pkg::*;

  // command and status between sequencer and datapath
  ohl_cmd_t cmd;
  ohl_sts_t sts;

  // sequencer: idle, remove walk, get read, commit
  ohl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: entry memory, length/max tracking, result register
  ohl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ rtl/ohl_ctrl.sv @@
// ohl_ctrl: sequencing state machine for the ordered handle list
// depends on ohl_pkg for the command/status structs and op codes
`timescale 1ns / 1ps

module ohl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  ohl_pkg::ohl_sts_t sts,
  output ohl_pkg::ohl_cmd_t cmd
);
  import ohl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WALK   = 4'b0010,
    S_READ   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.in_op == OP_REMOVE) begin
            state_next = S_WALK;
          end else if (sts.in_op == OP_GET) begin
            state_next = S_READ;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_WALK: begin
        if (sts.walk_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      S_READ: begin
        // memory read of the requested position lands next cycle
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy || out_ready) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ohl_dp.sv @@
// ohl_dp: entry memory, length and maximum registers, remove walk and result register
// depends on ohl_pkg for codes, widths and the command/status structs
`timescale 1ns / 1ps

module ohl_dp #(
  parameter int CAPACITY = ohl_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [ohl_pkg::IN_W-1:0] in_data,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [ohl_pkg::OUT_W-1:0] out_data,
  input  ohl_pkg::ohl_cmd_t        cmd,
  output ohl_pkg::ohl_sts_t        sts
);
  import ohl_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int LXW  = (CW > LEN_W) ? CW : LEN_W;

  logic [HANDLE_W-1:0] mem [CAPACITY];

  // request word
  logic [OP_W-1:0]     req_op;
  logic [HANDLE_W-1:0] req_handle;
  logic [POS_W-1:0]    req_pos;

  // list state
  logic [CW-1:0]       count;
  logic [HANDLE_W-1:0] max_val;

  // walk state
  logic [CW-1:0]       issue_idx;
  logic [CW-1:0]       data_idx;
  logic                data_vld;
  logic                found;
  logic [HANDLE_W-1:0] run_max;
  logic [HANDLE_W-1:0] rd_data;

  logic                res_valid;
  logic [OUT_W-1:0]    res_data;

  logic [CMPW-1:0]     pos_ext;
  logic [AW-1:0]       rd_addr;
  logic                issue_ok;
  logic [CW-1:0]       prev_idx;

  logic                we;
  logic [AW-1:0]       wa;
  logic [HANDLE_W-1:0] wd;

  logic [CW-1:0]       count_after;
  logic [HANDLE_W-1:0] max_after;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] fetched;
  logic [LXW-1:0]      len_ext;

  assign sts.in_op     = in_data[OP_W-1:0];
  assign sts.walk_done = !issue_ok && !data_vld;
  assign sts.out_busy  = res_valid;

  assign pos_ext  = CMPW'(req_pos);
  assign issue_ok = (issue_idx < count);
  assign prev_idx = data_idx - 1'b1;
  assign rd_addr  = (req_op == OP_REMOVE) ? issue_idx[AW-1:0] : pos_ext[AW-1:0];

  // single write port: shift during the walk, append at commit
  always_comb begin
    we = 1'b0;
    wa = count[AW-1:0];
    wd = req_handle;
    if (cmd.walk && data_vld && found) begin
      we = 1'b1;
      wa = prev_idx[AW-1:0];
      wd = rd_data;
    end else if (cmd.fin && req_op == OP_APPEND && count < CW'(CAPACITY)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  // outcome of the pending operation
  always_comb begin
    count_after = count;
    max_after   = max_val;
    status      = ST_MISSING;
    fetched     = '0;
    case (req_op)
      OP_APPEND: begin
        if (count < CW'(CAPACITY)) begin
          count_after = count + 1'b1;
          max_after   = (req_handle > max_val) ? req_handle : max_val;
          status      = ST_OK;
        end else begin
          status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          count_after = count - 1'b1;
          max_after   = run_max;
          status      = ST_OK;
        end
      end
      OP_GET: begin
        if (pos_ext < CMPW'(count)) begin
          fetched = rd_data;
          status  = ST_OK;
        end
      end
      default: begin
        status = ST_MISSING;
      end
    endcase
  end

  assign len_ext = LXW'(count_after);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      max_val   <= '0;
      res_valid <= 1'b0;
      data_vld  <= 1'b0;
      found     <= 1'b0;
      issue_idx <= '0;
    end else begin
      if (cmd.load) begin
        req_op     <= in_data[OP_W-1:0];
        req_handle <= in_data[OP_W +: HANDLE_W];
        req_pos    <= in_data[OP_W+HANDLE_W +: POS_W];
        issue_idx  <= '0;
        data_vld   <= 1'b0;
        found      <= 1'b0;
        run_max    <= '0;
      end
      if (cmd.walk) begin
        data_vld <= issue_ok;
        if (issue_ok) begin
          issue_idx <= issue_idx + 1'b1;
          data_idx  <= issue_idx;
        end
        if (data_vld) begin
          if (!found && rd_data == req_handle) begin
            // first match drops out; later entries move down one place
            found <= 1'b1;
          end else if (rd_data > run_max) begin
            run_max <= rd_data;
          end
        end
      end
      if (cmd.fin) begin
        count     <= count_after;
        max_val   <= max_after;
        res_valid <= 1'b1;
        res_data  <= {6'd0, (count_after != '0), max_after, len_ext[LEN_W-1:0],
                      fetched, status};
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign out_valid = res_valid;
  assign out_data  = res_data;

endmodule
